>>> design/per_address_rate_policer_assert.svh
`ifndef PER_ADDRESS_RATE_POLICER_ASSERT_SVH
`define PER_ADDRESS_RATE_POLICER_ASSERT_SVH

// Both macros expect signals named clk and rst in the scope where they are used.
`define PARP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("policer check failed");

`define PARP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("policer check failed");

`endif

>>> design/parp_pkg.sv
package parp_pkg;

  localparam int unsigned TableEntries  = 64;
  localparam int unsigned IdxW          = $clog2(TableEntries);
  localparam int unsigned WindowSlots   = 64;
  localparam int unsigned SlotW         = $clog2(WindowSlots);
  localparam int unsigned FillW         = SlotW + 1;
  localparam int unsigned WindowMs      = 1000;
  localparam int unsigned IdleMs        = 2 * WindowMs;
  localparam int unsigned MilliPerToken = 1000;
  localparam int unsigned TimeW         = 48;
  localparam int unsigned AddrW         = 32;
  localparam int unsigned TokW          = 17;
  localparam int unsigned RateW         = 7;
  localparam int unsigned BanW          = 12;
  localparam int unsigned BanMsW        = 22;
  localparam int unsigned ProdW         = TokW + RateW;
  localparam int unsigned SumW          = ProdW + 1;
  localparam int unsigned CmdW          = 2;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned CfgW          = 32;
  localparam int unsigned CfgIdxW       = 3;

  localparam logic [RateW-1:0] RateReset   = 7'd20;
  localparam logic [BanW-1:0]  BanReset    = 12'd10;
  localparam logic [AddrW-1:0] ExemptReset = 32'h7F00_0001;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE      = 3'd0,
    CFG_MODE        = 3'd1,
    CFG_MAX_RATE    = 3'd2,
    CFG_BAN_SECONDS = 3'd3,
    CFG_EXEMPT      = 3'd4
  } cfg_idx_t;

  typedef enum logic [CmdW-1:0] {
    CMD_REQUEST = 2'd0,
    CMD_BAN     = 2'd1,
    CMD_UNBAN   = 2'd2
  } cmd_t;

  typedef enum logic [StatusW-1:0] {
    ST_PASS      = 3'd0,
    ST_BANNED    = 3'd1,
    ST_NEW_BAN   = 3'd2,
    ST_DONE      = 3'd3,
    ST_REFUSED   = 3'd4,
    ST_UNTRACKED = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLASSIFY, S_SCAN, S_PICK, S_FETCH, S_DECIDE, S_LIMIT, S_BKT_FIN,
    S_WIN_RD, S_WIN_CHK, S_WIN_PUSH, S_APPLY, S_WRITE, S_RESULT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SCAN, OP_PICK, OP_FETCH, OP_UNBAN, OP_BKT_MUL, OP_BKT_FIN,
    OP_WIN_STEP, OP_WIN_PUSH, OP_BAN_AUTO, OP_BAN_MAN, OP_WRITE, OP_EMIT
  } op_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic             ban_active;
    logic             ban_forever;
    logic [TimeW-1:0] ban_until;
    logic             started;
    logic [TokW-1:0]  tokens;
    logic [TimeW-1:0] last;
    logic [TimeW-1:0] newest;
    logic [SlotW-1:0] head;
    logic [FillW-1:0] fill;
  } rec_t;

  typedef struct packed {
    op_t     op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic bypass;
    logic exempt_hit;
    logic scan_last;
    logic found;
    logic can_claim;
    logic ban_active;
    logic ban_live;
    logic mode;
    logic pass;
    logic win_more;
    logic out_free;
  } dp_stat_t;

endpackage

>>> design/parp_req_if.sv
interface parp_req_if;
  logic                        valid;
  logic                        ready;
  logic [parp_pkg::CmdW-1:0]   command;
  logic [parp_pkg::AddrW-1:0]  ip_address;
  logic [parp_pkg::TimeW-1:0]  now_ms;

  modport source (output valid, command, ip_address, now_ms, input ready);
  modport sink (input valid, command, ip_address, now_ms, output ready);
endinterface

>>> design/parp_res_if.sv
interface parp_res_if;
  logic                          valid;
  logic                          ready;
  logic                          allowed;
  logic [parp_pkg::StatusW-1:0]  status;

  modport source (output valid, allowed, status, input ready);
  modport sink (input valid, allowed, status, output ready);
endinterface

>>> design/parp_datapath.sv
module parp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [parp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [parp_pkg::CfgW-1:0]     cfg_data,
  parp_req_if.sink                      req,
  parp_res_if.source                    res,
  input  parp_pkg::dp_cmd_t             cmd,
  output parp_pkg::dp_stat_t            stat
);

  function automatic logic [parp_pkg::TimeW-1:0] gap48(
    input logic [parp_pkg::TimeW-1:0] later,
    input logic [parp_pkg::TimeW-1:0] earlier
  );
    return later - earlier;
  endfunction

  function automatic logic live_ban(input parp_pkg::rec_t r,
                                    input logic [parp_pkg::TimeW-1:0] now);
    return r.ban_active && (r.ban_forever || (r.ban_until > now));
  endfunction

  function automatic logic entry_idle(input parp_pkg::rec_t r,
                                      input logic [parp_pkg::TimeW-1:0] now);
    logic busy_bucket;
    logic busy_window;
    busy_bucket = r.started &&
                  (gap48(now, r.last) <= parp_pkg::TimeW'(parp_pkg::IdleMs));
    busy_window = (r.fill != '0) &&
                  (gap48(now, r.newest) < parp_pkg::TimeW'(parp_pkg::WindowMs));
    return !live_ban(r, now) && !busy_bucket && !busy_window;
  endfunction

  function automatic parp_pkg::rec_t clear_rate(input parp_pkg::rec_t r);
    parp_pkg::rec_t o;
    o = r;
    o.started = 1'b0;
    o.tokens  = '0;
    o.last    = '0;
    o.head    = '0;
    o.fill    = '0;
    return o;
  endfunction

  // A ban always wipes the rate state of the entry.
  function automatic parp_pkg::rec_t with_ban(input parp_pkg::rec_t r,
                                              input logic perm,
                                              input logic [parp_pkg::TimeW-1:0] end_ms);
    parp_pkg::rec_t o;
    o = clear_rate(r);
    o.ban_active  = 1'b1;
    o.ban_forever = perm;
    o.ban_until   = end_ms;
    return o;
  endfunction

  logic                             en_q;
  logic                             mode_q;
  logic [parp_pkg::RateW-1:0]       rate_q;
  logic [parp_pkg::BanW-1:0]        ban_s_q;
  logic [parp_pkg::AddrW-1:0]       exempt_q;

  logic [parp_pkg::CmdW-1:0]        cmd_q;
  logic [parp_pkg::AddrW-1:0]       addr_q;
  logic [parp_pkg::TimeW-1:0]       now_q;

  parp_pkg::rec_t                   rec_mem [parp_pkg::TableEntries];
  parp_pkg::rec_t                   rd_rec;
  parp_pkg::rec_t                   rec;
  parp_pkg::rec_t                   fresh;
  logic [parp_pkg::TimeW-1:0]       win_mem [parp_pkg::TableEntries * parp_pkg::WindowSlots];
  logic [parp_pkg::TimeW-1:0]       win_rd;
  logic [parp_pkg::TableEntries-1:0] valid_bits;

  logic [parp_pkg::IdxW:0]          cnt;
  logic [parp_pkg::IdxW-1:0]        scan_idx;
  logic [parp_pkg::IdxW-1:0]        hit_idx;
  logic [parp_pkg::IdxW-1:0]        inv_idx;
  logic [parp_pkg::IdxW-1:0]        idle_idx;
  logic [parp_pkg::IdxW-1:0]        idx;
  logic [parp_pkg::IdxW-1:0]        pick_idx;
  logic [parp_pkg::IdxW-1:0]        rd_addr;
  logic                             found;
  logic                             inv_found;
  logic                             idle_found;
  logic                             claimed;
  logic                             pass;
  logic                             scan_hit;
  logic                             scan_idle;

  logic [parp_pkg::TokW-1:0]        full;
  logic [parp_pkg::TokW-1:0]        tok0;
  logic [parp_pkg::TimeW-1:0]       last0;
  logic [parp_pkg::TimeW-1:0]       bkt_gap;
  logic [parp_pkg::TokW-1:0]        gap_clamp;
  logic [parp_pkg::ProdW-1:0]       prod;
  logic [parp_pkg::SumW-1:0]        tsum;
  logic [parp_pkg::TokW-1:0]        tsat;
  logic                             tok_ok;

  logic [parp_pkg::BanMsW-1:0]      ban_ms;
  logic [parp_pkg::TimeW:0]         until_sum;
  logic [parp_pkg::TimeW-1:0]       ban_end;

  logic [parp_pkg::FillW-1:0]       limit;
  logic [parp_pkg::SlotW-1:0]       tail;
  logic                             win_room;
  logic [parp_pkg::IdxW+parp_pkg::SlotW-1:0] win_raddr;
  logic [parp_pkg::IdxW+parp_pkg::SlotW-1:0] win_waddr;

  logic                             out_valid;
  logic                             out_allowed;
  logic [parp_pkg::StatusW-1:0]     out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      en_q     <= 1'b1;
      mode_q   <= 1'b0;
      rate_q   <= parp_pkg::RateReset;
      ban_s_q  <= parp_pkg::BanReset;
      exempt_q <= parp_pkg::ExemptReset;
    end else if (cfg_we) begin
      case (parp_pkg::cfg_idx_t'(cfg_index))
        parp_pkg::CFG_ENABLE:      en_q     <= cfg_data[0];
        parp_pkg::CFG_MODE:        mode_q   <= cfg_data[0];
        parp_pkg::CFG_MAX_RATE:    rate_q   <= cfg_data[parp_pkg::RateW-1:0];
        parp_pkg::CFG_BAN_SECONDS: ban_s_q  <= cfg_data[parp_pkg::BanW-1:0];
        parp_pkg::CFG_EXEMPT:      exempt_q <= cfg_data[parp_pkg::AddrW-1:0];
        default: ;
      endcase
    end
  end

  // The read issued with count k returns entry k in the next cycle.
  assign scan_idx  = cnt[parp_pkg::IdxW-1:0] - parp_pkg::IdxW'(1);
  assign scan_hit  = valid_bits[scan_idx] && (rd_rec.addr == addr_q);
  assign scan_idle = valid_bits[scan_idx] && entry_idle(rd_rec, now_q);
  assign pick_idx  = found ? hit_idx : (inv_found ? inv_idx : idle_idx);
  assign rd_addr   = (cmd.op == parp_pkg::OP_PICK) ? pick_idx : cnt[parp_pkg::IdxW-1:0];

  always_comb begin
    fresh      = '0;
    fresh.addr = addr_q;
  end

  // Any gap above the clamp already refills a bucket of the largest size.
  assign full      = parp_pkg::TokW'(rate_q * parp_pkg::MilliPerToken);
  assign tok0      = rec.started ? rec.tokens : full;
  assign last0     = rec.started ? rec.last : now_q;
  assign bkt_gap   = gap48(now_q, last0);
  assign gap_clamp = (|bkt_gap[parp_pkg::TimeW-1:parp_pkg::TokW]) ? '1 :
                     bkt_gap[parp_pkg::TokW-1:0];
  assign tsum      = parp_pkg::SumW'(rec.tokens) + parp_pkg::SumW'(prod);
  assign tsat      = (tsum > parp_pkg::SumW'(full)) ? full : tsum[parp_pkg::TokW-1:0];
  assign tok_ok    = tsat >= parp_pkg::TokW'(parp_pkg::MilliPerToken);

  assign ban_ms    = parp_pkg::BanMsW'(ban_s_q * parp_pkg::MilliPerToken);
  assign until_sum = {1'b0, now_q} + (parp_pkg::TimeW + 1)'(ban_ms);
  assign ban_end   = until_sum[parp_pkg::TimeW] ? '1 : until_sum[parp_pkg::TimeW-1:0];

  assign limit     = (rate_q >= parp_pkg::FillW'(parp_pkg::WindowSlots)) ?
                     parp_pkg::FillW'(parp_pkg::WindowSlots) : rate_q;
  assign tail      = rec.head + rec.fill[parp_pkg::SlotW-1:0];
  assign win_room  = rec.fill < limit;
  assign win_raddr = {idx, rec.head};
  assign win_waddr = {idx, tail};

  always_ff @(posedge clk) begin
    case (cmd.op)
      parp_pkg::OP_LOAD: begin
        cmd_q      <= req.command;
        addr_q     <= req.ip_address;
        now_q      <= req.now_ms;
        cnt        <= '0;
        found      <= 1'b0;
        inv_found  <= 1'b0;
        idle_found <= 1'b0;
      end
      parp_pkg::OP_SCAN: begin
        cnt <= cnt + 1'b1;
        if (cnt != '0) begin
          if (scan_hit && !found) begin
            found   <= 1'b1;
            hit_idx <= scan_idx;
          end
          if (!valid_bits[scan_idx] && !inv_found) begin
            inv_found <= 1'b1;
            inv_idx   <= scan_idx;
          end
          if (scan_idle && !idle_found) begin
            idle_found <= 1'b1;
            idle_idx   <= scan_idx;
          end
        end
      end
      parp_pkg::OP_PICK: begin
        idx     <= pick_idx;
        claimed <= !found;
      end
      parp_pkg::OP_FETCH: rec <= claimed ? fresh : rd_rec;
      parp_pkg::OP_UNBAN: begin
        rec.ban_active  <= 1'b0;
        rec.ban_forever <= 1'b0;
      end
      parp_pkg::OP_BKT_MUL: begin
        rec.started <= 1'b1;
        rec.tokens  <= tok0;
        prod        <= parp_pkg::ProdW'(gap_clamp) * parp_pkg::ProdW'(rate_q);
      end
      parp_pkg::OP_BKT_FIN: begin
        rec.last   <= now_q;
        rec.tokens <= tok_ok ? (tsat - parp_pkg::TokW'(parp_pkg::MilliPerToken)) : tsat;
        pass       <= tok_ok;
      end
      parp_pkg::OP_WIN_STEP: begin
        rec.head <= rec.head + 1'b1;
        rec.fill <= rec.fill - 1'b1;
      end
      parp_pkg::OP_WIN_PUSH: begin
        pass <= win_room;
        if (win_room) begin
          rec.fill   <= rec.fill + 1'b1;
          rec.newest <= now_q;
        end
      end
      parp_pkg::OP_BAN_AUTO: rec <= with_ban(rec, 1'b0, ban_end);
      parp_pkg::OP_BAN_MAN:  rec <= with_ban(rec, 1'b1, '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_rec <= rec_mem[rd_addr];
    if (cmd.op == parp_pkg::OP_WRITE) begin
      rec_mem[idx] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    win_rd <= win_mem[win_raddr];
    if (cmd.op == parp_pkg::OP_WIN_PUSH && win_room) begin
      win_mem[win_waddr] <= now_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (cmd.op == parp_pkg::OP_WRITE) begin
      valid_bits[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == parp_pkg::OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == parp_pkg::OP_EMIT) begin
      out_status  <= cmd.code;
      out_allowed <= (cmd.code == parp_pkg::ST_PASS) || (cmd.code == parp_pkg::ST_DONE) ||
                     (cmd.code == parp_pkg::ST_UNTRACKED);
    end
  end

  assign res.valid   = out_valid;
  assign res.allowed = out_allowed;
  assign res.status  = out_status;

  assign stat.cmd        = parp_pkg::cmd_t'(cmd_q);
  assign stat.exempt_hit = addr_q == exempt_q;
  assign stat.bypass     = !en_q || (addr_q == exempt_q);
  assign stat.scan_last  = cnt == (parp_pkg::IdxW + 1)'(parp_pkg::TableEntries);
  assign stat.found      = found;
  assign stat.can_claim  = inv_found || idle_found;
  assign stat.ban_active = rec.ban_active;
  assign stat.ban_live   = live_ban(rec, now_q);
  assign stat.mode       = mode_q;
  assign stat.pass       = pass;
  assign stat.win_more   = (rec.fill != '0) &&
                           (gap48(now_q, win_rd) >= parp_pkg::TimeW'(parp_pkg::WindowMs));
  assign stat.out_free   = !out_valid || res.ready;

endmodule

>>> design/parp_ctrl.sv
module parp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                ready,
  input  parp_pkg::dp_stat_t  stat,
  output parp_pkg::dp_cmd_t   cmd
);

  parp_pkg::state_t  state;
  parp_pkg::state_t  state_next;
  parp_pkg::status_t code;
  parp_pkg::status_t code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= parp_pkg::S_IDLE;
      code  <= parp_pkg::ST_PASS;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    code_next  = code;
    cmd.op     = parp_pkg::OP_NONE;
    cmd.code   = code;
    ready      = 1'b0;
    case (state)
      parp_pkg::S_IDLE: begin
        ready = 1'b1;
        if (req_valid) begin
          cmd.op     = parp_pkg::OP_LOAD;
          state_next = parp_pkg::S_CLASSIFY;
        end
      end
      parp_pkg::S_CLASSIFY: begin
        case (stat.cmd)
          parp_pkg::CMD_REQUEST: begin
            if (stat.bypass) begin
              code_next  = parp_pkg::ST_PASS;
              state_next = parp_pkg::S_RESULT;
            end else begin
              state_next = parp_pkg::S_SCAN;
            end
          end
          parp_pkg::CMD_BAN: begin
            if (stat.exempt_hit) begin
              code_next  = parp_pkg::ST_REFUSED;
              state_next = parp_pkg::S_RESULT;
            end else begin
              state_next = parp_pkg::S_SCAN;
            end
          end
          parp_pkg::CMD_UNBAN: state_next = parp_pkg::S_SCAN;
          default: begin
            code_next  = parp_pkg::ST_REFUSED;
            state_next = parp_pkg::S_RESULT;
          end
        endcase
      end
      parp_pkg::S_SCAN: begin
        cmd.op = parp_pkg::OP_SCAN;
        if (stat.scan_last) begin
          state_next = parp_pkg::S_PICK;
        end
      end
      parp_pkg::S_PICK: begin
        if (!stat.found && (stat.cmd == parp_pkg::CMD_UNBAN || !stat.can_claim)) begin
          code_next  = (stat.cmd == parp_pkg::CMD_REQUEST) ? parp_pkg::ST_UNTRACKED :
                       parp_pkg::ST_REFUSED;
          state_next = parp_pkg::S_RESULT;
        end else begin
          cmd.op     = parp_pkg::OP_PICK;
          state_next = parp_pkg::S_FETCH;
        end
      end
      parp_pkg::S_FETCH: begin
        cmd.op     = parp_pkg::OP_FETCH;
        state_next = parp_pkg::S_DECIDE;
      end
      parp_pkg::S_DECIDE: begin
        case (stat.cmd)
          parp_pkg::CMD_REQUEST: begin
            if (stat.ban_live) begin
              code_next  = parp_pkg::ST_BANNED;
              state_next = parp_pkg::S_RESULT;
            end else begin
              // An expired ban is lifted before the limiter looks at the entry.
              if (stat.ban_active) begin
                cmd.op = parp_pkg::OP_UNBAN;
              end
              state_next = parp_pkg::S_LIMIT;
            end
          end
          parp_pkg::CMD_BAN: begin
            cmd.op     = parp_pkg::OP_BAN_MAN;
            code_next  = parp_pkg::ST_DONE;
            state_next = parp_pkg::S_WRITE;
          end
          parp_pkg::CMD_UNBAN: begin
            if (stat.ban_active) begin
              cmd.op     = parp_pkg::OP_UNBAN;
              code_next  = parp_pkg::ST_DONE;
              state_next = parp_pkg::S_WRITE;
            end else begin
              code_next  = parp_pkg::ST_REFUSED;
              state_next = parp_pkg::S_RESULT;
            end
          end
          default: begin
            code_next  = parp_pkg::ST_REFUSED;
            state_next = parp_pkg::S_RESULT;
          end
        endcase
      end
      parp_pkg::S_LIMIT: begin
        if (stat.mode) begin
          state_next = parp_pkg::S_WIN_RD;
        end else begin
          cmd.op     = parp_pkg::OP_BKT_MUL;
          state_next = parp_pkg::S_BKT_FIN;
        end
      end
      parp_pkg::S_BKT_FIN: begin
        cmd.op     = parp_pkg::OP_BKT_FIN;
        state_next = parp_pkg::S_APPLY;
      end
      parp_pkg::S_WIN_RD: state_next = parp_pkg::S_WIN_CHK;
      parp_pkg::S_WIN_CHK: begin
        if (stat.win_more) begin
          cmd.op     = parp_pkg::OP_WIN_STEP;
          state_next = parp_pkg::S_WIN_RD;
        end else begin
          state_next = parp_pkg::S_WIN_PUSH;
        end
      end
      parp_pkg::S_WIN_PUSH: begin
        cmd.op     = parp_pkg::OP_WIN_PUSH;
        state_next = parp_pkg::S_APPLY;
      end
      parp_pkg::S_APPLY: begin
        if (stat.pass) begin
          code_next = parp_pkg::ST_PASS;
        end else begin
          cmd.op    = parp_pkg::OP_BAN_AUTO;
          code_next = parp_pkg::ST_NEW_BAN;
        end
        state_next = parp_pkg::S_WRITE;
      end
      parp_pkg::S_WRITE: begin
        cmd.op     = parp_pkg::OP_WRITE;
        state_next = parp_pkg::S_RESULT;
      end
      parp_pkg::S_RESULT: begin
        if (stat.out_free) begin
          cmd.op     = parp_pkg::OP_EMIT;
          state_next = parp_pkg::S_IDLE;
        end
      end
      default: state_next = parp_pkg::S_IDLE;
    endcase
  end

endmodule

>>> design/per_address_rate_policer.sv
// Polices requests per IPv4 address with a token bucket or a one-second sliding window,
// over a 64-entry table. One word is worked on at a time. A request that bypasses the
// table (policing off, exempt address), a ban of the exempt address or an unknown command
// goes straight to the result. Anything that needs the table first scans all 64 entries
// through the single read port of the entry memory. In window mode each expired
// timestamp needs its own read from the stamp memory before the new one is pushed.
// The result sits in an output register, so the next word is taken while it waits.
// Table entries become usable right after reset; there is no clearing pass.
module per_address_rate_policer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [parp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [parp_pkg::CfgW-1:0]     cfg_data,
  parp_req_if.sink                      req,
  parp_res_if.source                    res
);

  parp_pkg::dp_cmd_t  cmd;
  parp_pkg::dp_stat_t stat;
  logic               ready;

  assign req.ready = ready;

  parp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .ready     (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  parp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .res       (res),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> design/parp_checker.sv
`include "per_address_rate_policer_assert.svh"

module parp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          res_allowed,
  input logic [parp_pkg::StatusW-1:0]  res_status
);

  // A waiting result keeps its value until it is taken.
  `PARP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_allowed))

  // The pass flag must agree with the status code.
  `PARP_ASSERT_SAME(a_allowed_match, res_valid, res_allowed == ((res_status == parp_pkg::ST_PASS) || (res_status == parp_pkg::ST_DONE) || (res_status == parp_pkg::ST_UNTRACKED)))

  // After an accept the controller leaves S_IDLE, so acceptance never repeats back to back.
  `PARP_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

endmodule

bind per_address_rate_policer parp_checker u_parp_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_allowed (res.allowed),
  .res_status  (res.status)
);

>>> tb/tb_per_address_rate_policer.sv
`timescale 1ns / 1ps

module tb_per_address_rate_policer;

  localparam logic [parp_pkg::CmdW-1:0] CmdUnknown = 2'd3;
  localparam logic [parp_pkg::TimeW-1:0] TimeMax = {parp_pkg::TimeW{1'b1}};
  localparam int CycleLimit = 1_000_000;
  localparam int PendDepth = 4096;

  typedef struct packed {
    logic              allowed;
    parp_pkg::status_t status;
  } verdict_t;

  // Mirrors the policer table and decides each word's verdict when it is accepted.
  class policer_verdicts;
    bit                            en;
    bit                            win_mode;
    bit [parp_pkg::RateW-1:0]      rate;
    bit [parp_pkg::BanW-1:0]       ban_s;
    bit [parp_pkg::AddrW-1:0]      exempt;
    bit                            used[parp_pkg::TableEntries];
    bit [parp_pkg::AddrW-1:0]      addr_of[parp_pkg::TableEntries];
    bit                            banned[parp_pkg::TableEntries];
    bit                            perm[parp_pkg::TableEntries];
    bit [parp_pkg::TimeW-1:0]      ban_end[parp_pkg::TableEntries];
    bit                            started[parp_pkg::TableEntries];
    bit [parp_pkg::TokW-1:0]       tokens[parp_pkg::TableEntries];
    bit [parp_pkg::TimeW-1:0]      last_fill[parp_pkg::TableEntries];
    bit [parp_pkg::TimeW-1:0]      stamps[parp_pkg::TableEntries][parp_pkg::WindowSlots];
    bit [parp_pkg::SlotW-1:0]      head[parp_pkg::TableEntries];
    bit [parp_pkg::FillW-1:0]      fill[parp_pkg::TableEntries];
    verdict_t                      pending[PendDepth];
    int                            put_n;
    int                            take_n;
    int                            errors;

    function new();
      en = 1'b1;
      win_mode = 1'b0;
      rate = parp_pkg::RateReset;
      ban_s = parp_pkg::BanReset;
      exempt = parp_pkg::ExemptReset;
      errors = 0;
      put_n = 0;
      take_n = 0;
      for (int s = 0; s < parp_pkg::TableEntries; s++) begin
        used[s] = 0;
        banned[s] = 0;
        perm[s] = 0;
        started[s] = 0;
        head[s] = 0;
        fill[s] = 0;
      end
    endfunction

    function int outstanding();
      return put_n - take_n;
    endfunction

    function void write_reg(parp_pkg::cfg_idx_t idx, bit [parp_pkg::CfgW-1:0] v);
      case (idx)
        parp_pkg::CFG_ENABLE:      en = v[0];
        parp_pkg::CFG_MODE:        win_mode = v[0];
        parp_pkg::CFG_MAX_RATE:    rate = v[parp_pkg::RateW-1:0];
        parp_pkg::CFG_BAN_SECONDS: ban_s = v[parp_pkg::BanW-1:0];
        parp_pkg::CFG_EXEMPT:      exempt = v[parp_pkg::AddrW-1:0];
        default: ;
      endcase
    endfunction

    function int find_slot(bit [parp_pkg::AddrW-1:0] a);
      for (int s = 0; s < parp_pkg::TableEntries; s++)
        if (used[s] && addr_of[s] == a) return s;
      return -1;
    endfunction

    function bit ban_live(int s, bit [parp_pkg::TimeW-1:0] now);
      return banned[s] && (perm[s] || ban_end[s] > now);
    endfunction

    function void wipe_rate(int s);
      started[s] = 0;
      tokens[s] = 0;
      last_fill[s] = 0;
      head[s] = 0;
      fill[s] = 0;
    endfunction

    function bit slot_idle(int s, bit [parp_pkg::TimeW-1:0] now);
      bit [parp_pkg::SlotW-1:0] nw;
      bit [parp_pkg::TimeW-1:0] g;
      if (ban_live(s, now)) return 0;
      g = now - last_fill[s];
      if (started[s] && g <= parp_pkg::IdleMs) return 0;
      if (fill[s] != 0) begin
        nw = head[s] + fill[s] - 1;
        g = now - stamps[s][nw];
        if (g < parp_pkg::WindowMs) return 0;
      end
      return 1;
    endfunction

    function int claim_slot(bit [parp_pkg::AddrW-1:0] a, bit [parp_pkg::TimeW-1:0] now);
      int pick;
      pick = -1;
      for (int s = 0; s < parp_pkg::TableEntries && pick < 0; s++)
        if (!used[s]) pick = s;
      for (int s = 0; s < parp_pkg::TableEntries && pick < 0; s++)
        if (slot_idle(s, now)) pick = s;
      if (pick < 0) return -1;
      used[pick] = 1;
      addr_of[pick] = a;
      banned[pick] = 0;
      perm[pick] = 0;
      ban_end[pick] = 0;
      wipe_rate(pick);
      return pick;
    endfunction

    function bit bucket_ok(int s, bit [parp_pkg::TimeW-1:0] now);
      longint unsigned full, t;
      bit [parp_pkg::TimeW-1:0] g;
      full = longint'(rate) * parp_pkg::MilliPerToken;
      if (!started[s]) begin
        started[s] = 1;
        tokens[s] = full;
        last_fill[s] = now;
      end
      g = now - last_fill[s];
      t = longint'(tokens[s]) + longint'(g) * longint'(rate);
      if (t > full) t = full;
      last_fill[s] = now;
      if (t < parp_pkg::MilliPerToken) begin
        tokens[s] = t;
        return 0;
      end
      tokens[s] = t - parp_pkg::MilliPerToken;
      return 1;
    endfunction

    function bit window_ok(int s, bit [parp_pkg::TimeW-1:0] now);
      int lim;
      bit [parp_pkg::TimeW-1:0] g;
      bit [parp_pkg::SlotW-1:0] tail;
      lim = (rate < parp_pkg::WindowSlots) ? rate : parp_pkg::WindowSlots;
      while (fill[s] != 0) begin
        g = now - stamps[s][head[s]];
        if (g < parp_pkg::WindowMs) break;
        head[s] = head[s] + 1;
        fill[s] = fill[s] - 1;
      end
      if (fill[s] >= lim) return 0;
      tail = head[s] + fill[s];
      stamps[s][tail] = now;
      fill[s] = fill[s] + 1;
      return 1;
    endfunction

    function void note_word(bit [parp_pkg::CmdW-1:0] cmd, bit [parp_pkg::AddrW-1:0] a,
                            bit [parp_pkg::TimeW-1:0] now);
      verdict_t v;
      int s;
      longint unsigned u;
      v.allowed = 0;
      v.status = parp_pkg::ST_REFUSED;
      case (cmd)
        parp_pkg::CMD_REQUEST: begin
          if (!en || a == exempt) begin
            v.allowed = 1;
            v.status = parp_pkg::ST_PASS;
          end else begin
            s = find_slot(a);
            if (s >= 0 && banned[s]) begin
              if (ban_live(s, now)) begin
                s = -2;
                v.status = parp_pkg::ST_BANNED;
              end else begin
                banned[s] = 0;
                perm[s] = 0;
              end
            end
            if (s == -1) s = claim_slot(a, now);
            if (s == -1) begin
              v.allowed = 1;
              v.status = parp_pkg::ST_UNTRACKED;
            end else if (s >= 0) begin
              if (win_mode ? window_ok(s, now) : bucket_ok(s, now)) begin
                v.allowed = 1;
                v.status = parp_pkg::ST_PASS;
              end else begin
                u = longint'(now) + longint'(ban_s) * 1000;
                if (u > longint'(TimeMax)) u = TimeMax;
                banned[s] = 1;
                perm[s] = 0;
                ban_end[s] = u;
                wipe_rate(s);
                v.status = parp_pkg::ST_NEW_BAN;
              end
            end
          end
        end
        parp_pkg::CMD_BAN: begin
          if (a != exempt) begin
            s = find_slot(a);
            if (s < 0) s = claim_slot(a, now);
            if (s >= 0) begin
              banned[s] = 1;
              perm[s] = 1;
              ban_end[s] = 0;
              wipe_rate(s);
              v.allowed = 1;
              v.status = parp_pkg::ST_DONE;
            end
          end
        end
        parp_pkg::CMD_UNBAN: begin
          s = find_slot(a);
          if (s >= 0 && banned[s]) begin
            banned[s] = 0;
            perm[s] = 0;
            v.allowed = 1;
            v.status = parp_pkg::ST_DONE;
          end
        end
        default: ;
      endcase
      pending[put_n % PendDepth] = v;
      put_n++;
    endfunction

    function void check_word(bit al, bit [parp_pkg::StatusW-1:0] st);
      verdict_t v;
      if (outstanding() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: allowed %0d status %0d", al, st);
        return;
      end
      v = pending[take_n % PendDepth];
      take_n++;
      if (v.allowed !== al || v.status !== st) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected allowed %0d status %0d, got allowed %0d status %0d",
                   v.allowed, v.status, al, st);
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [parp_pkg::CfgIdxW-1:0]  cfg_index;
  logic [parp_pkg::CfgW-1:0]     cfg_data;
  parp_req_if                    req_ch();
  parp_res_if                    res_ch();

  policer_verdicts               book = new();
  int                            cycles = 0;
  int                            item_no = 0;
  bit [parp_pkg::TimeW-1:0]      clock_ms;
  bit [parp_pkg::AddrW-1:0]      pool[96];

  per_address_rate_policer u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch), .res(res_ch)
  );

  // A long stretch of words runs with neither side idling.
  function bit quiet();
    return item_no >= 400 && item_no < 550;
  endfunction

  initial clk = 0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[per_address_rate_policer] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_ch.ready <= !rst && (quiet() || $urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        book.note_word(req_ch.command, req_ch.ip_address, req_ch.now_ms);
      if (res_ch.valid && res_ch.ready)
        book.check_word(res_ch.allowed, res_ch.status);
    end
  end

  task automatic send_word(bit [parp_pkg::CmdW-1:0] cmd, bit [parp_pkg::AddrW-1:0] a,
                           bit [parp_pkg::TimeW-1:0] now);
    if (!quiet() && $urandom_range(99) < 17) begin
      req_ch.valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_ch.valid <= 1;
    req_ch.command <= cmd;
    req_ch.ip_address <= a;
    req_ch.now_ms <= now;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    item_no++;
  endtask

  task automatic apply_setting(bit e, bit m, bit [parp_pkg::RateW-1:0] r,
                               bit [parp_pkg::BanW-1:0] b, bit [parp_pkg::AddrW-1:0] x);
    bit [parp_pkg::CfgW-1:0] vals[5];
    vals = '{e, m, r, b, x};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_we <= 1;
      cfg_index <= parp_pkg::cfg_idx_t'(i);
      cfg_data <= vals[i];
      book.write_reg(parp_pkg::cfg_idx_t'(i), vals[i]);
    end
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // After an accept the block holds ready low until the word is finished, so a late
  // drop of valid causes no repeat.
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_word();
    bit [parp_pkg::CmdW-1:0] cmd;
    bit [parp_pkg::AddrW-1:0] a;
    int p;
    p = $urandom_range(99);
    if (p < 80) clock_ms += $urandom_range(0, 60);
    else if (p < 92) clock_ms += $urandom_range(100, 3000);
    else if (p < 96) clock_ms += $urandom_range(3000, 20000);
    else if (p < 98) clock_ms -= $urandom_range(1, 5000);
    else clock_ms = parp_pkg::TimeW'({$urandom, $urandom});
    p = $urandom_range(99);
    if (p < 50) a = pool[$urandom_range(0, 7)];
    else if (p < 90) a = pool[$urandom_range(0, 95)];
    else if (p < 95) a = book.exempt;
    else a = $urandom;
    p = $urandom_range(99);
    if (p < 85) cmd = parp_pkg::CMD_REQUEST;
    else if (p < 90) cmd = parp_pkg::CMD_BAN;
    else if (p < 98) cmd = parp_pkg::CMD_UNBAN;
    else cmd = CmdUnknown;
    send_word(cmd, a, clock_ms);
  endtask

  initial begin
    bit [parp_pkg::CfgW-1:0] phase_cfg[9][5];
    rst = 1;
    cfg_we = 0;
    cfg_index = parp_pkg::CFG_ENABLE;
    cfg_data = 0;
    req_ch.valid = 0;
    req_ch.command = parp_pkg::CMD_REQUEST;
    req_ch.ip_address = 0;
    req_ch.now_ms = 0;
    res_ch.ready = 0;
    for (int i = 0; i < 96; i++) pool[i] = 32'h0A00_0000 + i * 257 + 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: a small bucket so that a burst gets banned quickly.
    apply_setting(1, 0, 4, 10, parp_pkg::ExemptReset);
    send_word(parp_pkg::CMD_REQUEST, parp_pkg::ExemptReset, 1000);
    send_word(parp_pkg::CMD_BAN, parp_pkg::ExemptReset, 1000);
    send_word(parp_pkg::CMD_UNBAN, pool[0], 1000);
    send_word(CmdUnknown, pool[0], 1000);
    for (int i = 0; i < 5; i++) send_word(parp_pkg::CMD_REQUEST, pool[0], 1000);
    send_word(parp_pkg::CMD_REQUEST, pool[0], 2000);
    send_word(parp_pkg::CMD_UNBAN, pool[0], 2500);
    send_word(parp_pkg::CMD_REQUEST, pool[0], 2600);
    send_word(parp_pkg::CMD_BAN, 32'hFFFF_FFFF, 3000);
    send_word(parp_pkg::CMD_REQUEST, 32'hFFFF_FFFF, 3000);
    send_word(parp_pkg::CMD_UNBAN, 32'hFFFF_FFFF, 3100);
    send_word(parp_pkg::CMD_UNBAN, 32'hFFFF_FFFF, 3200);
    send_word(parp_pkg::CMD_REQUEST, 32'h0000_0000, TimeMax);
    send_word(parp_pkg::CMD_REQUEST, 32'h0000_0000, 5);
    for (int i = 0; i < 5; i++) send_word(parp_pkg::CMD_REQUEST, pool[1], TimeMax - 2);
    send_word(parp_pkg::CMD_REQUEST, pool[1], TimeMax);
    drain();

    phase_cfg = '{
      '{1, 0, 20, 10, parp_pkg::ExemptReset},
      '{1, 1, 20, 10, parp_pkg::ExemptReset},
      '{1, 0, 1, 0, pool[3]},
      '{1, 1, 64, 3600, 32'hFFFF_FFFF},
      '{0, 0, 5, 2, parp_pkg::ExemptReset},
      '{1, 1, 127, 4095, 32'h0000_0000},
      '{1, 0, 0, 1, parp_pkg::ExemptReset},
      '{1, 1, 3, 1, pool[5]},
      '{1, 0, 64, 1, parp_pkg::ExemptReset}
    };
    clock_ms = 10000;
    for (int ph = 0; ph < 9; ph++) begin
      apply_setting(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2],
                    phase_cfg[ph][3], phase_cfg[ph][4]);
      for (int i = 0; i < 128; i++) random_word();
      drain();
    end

    drain();
    repeat (250) @(posedge clk);
    if (book.errors == 0 && book.outstanding() == 0)
      $display("[per_address_rate_policer] OK");
    else
      $display("[per_address_rate_policer] ERROR");
    $finish;
  end

endmodule
